// ===== hw/rtl/ctpd_pkg.sv =====
// Package for the circumcircle block: widths, sequencer codes, and the sign-extension and
// saturating offset helpers. No dependencies.
package ctpd_pkg;

  localparam int CW    = 32;              // coordinate width
  localparam int RW    = CW - 1;          // radius / gap width
  localparam int MW    = CW + 1;          // coordinate difference width
  localparam int AW    = 3 * CW + 8;      // accumulator / numerator width
  localparam int DW    = 2 * CW + 4;      // divisor and radicand width
  localparam int QW    = CW + 4;          // quotient register width
  localparam int RTW   = DW / 2;          // root bits
  localparam int CNTW  = $clog2(AW);
  localparam int INW   = ((6 * CW + 7) / 8) * 8;
  localparam int OUTB  = 4 * CW + 2 * RW;
  localparam int OUTW  = ((OUTB + 7) / 8) * 8;
  localparam int PW    = 5;

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [RW-1:0] RMAX = {RW{1'b1}};

  // control states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DIVR  = 3'd4;
  localparam logic [2:0] ST_SQRT  = 3'd5;
  localparam logic [2:0] ST_SQRR  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  // issue kinds
  localparam logic [2:0] I_NONE = 3'd0;
  localparam logic [2:0] I_MAC  = 3'd1;
  localparam logic [2:0] I_DIV  = 3'd2;
  localparam logic [2:0] I_SQRT = 3'd3;
  localparam logic [2:0] I_OUT  = 3'd4;

  // program steps, load then query
  localparam logic [PW-1:0] P_L0  = 5'd0;
  localparam logic [PW-1:0] P_L1  = 5'd1;
  localparam logic [PW-1:0] P_L2  = 5'd2;
  localparam logic [PW-1:0] P_L3  = 5'd3;
  localparam logic [PW-1:0] P_L4  = 5'd4;
  localparam logic [PW-1:0] P_L5  = 5'd5;
  localparam logic [PW-1:0] P_L6  = 5'd6;
  localparam logic [PW-1:0] P_L7  = 5'd7;
  localparam logic [PW-1:0] P_L8  = 5'd8;
  localparam logic [PW-1:0] P_L9  = 5'd9;
  localparam logic [PW-1:0] P_L10 = 5'd10;
  localparam logic [PW-1:0] P_L11 = 5'd11;
  localparam logic [PW-1:0] P_L12 = 5'd12;
  localparam logic [PW-1:0] P_L13 = 5'd13;
  localparam logic [PW-1:0] P_L14 = 5'd14;
  localparam logic [PW-1:0] P_L15 = 5'd15;
  localparam logic [PW-1:0] P_L16 = 5'd16;
  localparam logic [PW-1:0] P_L17 = 5'd17;
  localparam logic [PW-1:0] P_L18 = 5'd18;
  localparam logic [PW-1:0] P_QZ  = 5'd19;
  localparam logic [PW-1:0] P_Q0  = 5'd20;
  localparam logic [PW-1:0] P_Q1  = 5'd21;
  localparam logic [PW-1:0] P_Q2  = 5'd22;
  localparam logic [PW-1:0] P_Q3  = 5'd23;
  localparam logic [PW-1:0] P_Q4  = 5'd24;
  localparam logic [PW-1:0] P_Q5  = 5'd25;
  localparam logic [PW-1:0] P_Q6  = 5'd26;
  localparam logic [PW-1:0] P_Q7  = 5'd27;

  typedef logic [CW-1:0] coord_t;

  function automatic logic [AW-1:0] sx_m(input logic [MW-1:0] v);
    return {{(AW-MW){v[MW-1]}}, v};
  endfunction

  // base +/- q, clamped to the coordinate range; ovf means q is huge
  function automatic coord_t place(input coord_t base, input logic [QW-1:0] q,
                                   input logic ovf, input logic neg);
    logic [QW+1:0] b_ext;
    logic [QW+1:0] q_ext;
    logic [QW+1:0] s;
    b_ext = {{(QW+2-CW){base[CW-1]}}, base};
    q_ext = {2'b00, q};
    s = neg ? b_ext - q_ext : b_ext + q_ext;
    if (ovf) return neg ? CMIN : CMAX;
    if (s[QW+1:CW-1] == '0 || s[QW+1:CW-1] == '1) return s[CW-1:0];
    return s[QW+1] ? CMIN : CMAX;
  endfunction

endpackage

// ===== hw/rtl/circle_three_point_and_distance.sv =====
// Circumcircle from three points with nearest-point / distance query.
// A collinear load (zero determinant) ends early and a query at the center skips the arithmetic;
// one item in flight, the next can be taken in the cycle after the result word leaves.
// Multiply-accumulate, division and square root all run on the shared add/sub unit.
// Reset (rst, synchronous) clears the circle.
module circle_three_point_and_distance (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ctpd_pkg::INW-1:0]    s_tdata,   // ax, ay, bx, by, cx, cy
  input  logic                        s_tuser,   // func
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ctpd_pkg::OUTW-1:0]   m_tdata,   // center_x, center_y, radius,
                                                 // near_x, near_y, gap, pad
  output logic                        m_tuser    // degenerate
);

  localparam int CW   = ctpd_pkg::CW;
  localparam int RW   = ctpd_pkg::RW;
  localparam int MW   = ctpd_pkg::MW;
  localparam int AW   = ctpd_pkg::AW;
  localparam int DW   = ctpd_pkg::DW;
  localparam int QW   = ctpd_pkg::QW;
  localparam int RTW  = ctpd_pkg::RTW;
  localparam int CNTW = ctpd_pkg::CNTW;
  localparam int PW   = ctpd_pkg::PW;

  logic [2:0]      st;
  logic [PW-1:0]   pc;
  logic [CW-1:0]   ax_q, ay_q;
  logic [MW-1:0]   x2, y2, x3, y3;
  logic [AW-1:0]   r2, r3, det, n1, n2;
  logic [AW-1:0]   acc, sh;
  logic [QW-1:0]   qr;
  logic            ovf, mac_sub, neg_q, dneg;
  logic [DW-1:0]   dv;
  logic [RTW-1:0]  qdist;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   center_x_reg, center_y_reg, near_x, near_y;
  logic [RW-1:0]   radius_reg, gap;
  logic            degen;

  logic [CW-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  assign in_ax = s_tdata[CW-1:0];
  assign in_ay = s_tdata[2*CW-1:CW];
  assign in_bx = s_tdata[3*CW-1:2*CW];
  assign in_by = s_tdata[4*CW-1:3*CW];
  assign in_cx = s_tdata[5*CW-1:4*CW];
  assign in_cy = s_tdata[6*CW-1:5*CW];

  // shared add/sub unit
  logic [AW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_res;
  logic          borrow;

  // issue decode
  logic [2:0]    iss;
  logic [AW-1:0] m_op;
  logic [MW-1:0] q_op;
  logic          sub_op, clr_op;
  logic [AW-1:0] abs_src, abs_val;

  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (st)
      ctpd_pkg::ST_MAC: begin
        alu_b   = qr[0] ? sh : '0;
        alu_sub = mac_sub ^ (cnt == CNTW'(MW-1));  // sign bit of multiplier
      end
      ctpd_pkg::ST_DIV: begin
        alu_a   = {acc[AW-2:0], sh[AW-1]};
        alu_b   = AW'(dv);
        alu_sub = 1'b1;
      end
      ctpd_pkg::ST_DIVR: begin
        alu_a   = {acc[AW-2:0], 1'b0};
        alu_b   = AW'(dv);
        alu_sub = 1'b1;
      end
      ctpd_pkg::ST_SQRT: begin
        alu_a   = {acc[AW-3:0], sh[AW-1:AW-2]};
        alu_b   = AW'({qr[RTW-1:0], 2'b01});
        alu_sub = 1'b1;
      end
      ctpd_pkg::ST_SQRR: begin
        alu_a   = AW'(qr[RTW-1:0]);
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      ctpd_pkg::ST_ISSUE: begin
        alu_a   = '0;
        alu_b   = abs_src;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign borrow  = alu_res[AW];
  assign abs_val = abs_src[AW-1] ? alu_res[AW-1:0] : abs_src;

  always_comb begin
    iss     = ctpd_pkg::I_NONE;
    m_op    = '0;
    q_op    = '0;
    sub_op  = 1'b0;
    clr_op  = 1'b0;
    abs_src = n1;
    unique case (pc)
      ctpd_pkg::P_L0, ctpd_pkg::P_L15, ctpd_pkg::P_Q0: begin
        iss = ctpd_pkg::I_MAC; m_op = ctpd_pkg::sx_m(x2); q_op = x2; clr_op = 1'b1;
      end
      ctpd_pkg::P_L1, ctpd_pkg::P_L16, ctpd_pkg::P_Q1: begin
        iss = ctpd_pkg::I_MAC; m_op = ctpd_pkg::sx_m(y2); q_op = y2;
      end
      ctpd_pkg::P_L2: begin
        iss = ctpd_pkg::I_MAC; m_op = ctpd_pkg::sx_m(x3); q_op = x3; clr_op = 1'b1;
      end
      ctpd_pkg::P_L3: begin
        iss = ctpd_pkg::I_MAC; m_op = ctpd_pkg::sx_m(y3); q_op = y3;
      end
      ctpd_pkg::P_L4: begin
        iss = ctpd_pkg::I_MAC; m_op = ctpd_pkg::sx_m(x2); q_op = y3; clr_op = 1'b1;
      end
      ctpd_pkg::P_L5: begin
        iss = ctpd_pkg::I_MAC; m_op = ctpd_pkg::sx_m(y2); q_op = x3; sub_op = 1'b1;
      end
      ctpd_pkg::P_L6: begin
        iss = (acc == '0) ? ctpd_pkg::I_OUT : ctpd_pkg::I_MAC;
        m_op = r2; q_op = y3; clr_op = 1'b1;
      end
      ctpd_pkg::P_L7: begin
        iss = ctpd_pkg::I_MAC; m_op = r3; q_op = y2; sub_op = 1'b1;
      end
      ctpd_pkg::P_L8: begin
        iss = ctpd_pkg::I_MAC; m_op = r3; q_op = x2; clr_op = 1'b1;
      end
      ctpd_pkg::P_L9: begin
        iss = ctpd_pkg::I_MAC; m_op = r2; q_op = x3; sub_op = 1'b1;
      end
      ctpd_pkg::P_L10: abs_src = det;
      ctpd_pkg::P_L11, ctpd_pkg::P_Q5: begin
        iss = ctpd_pkg::I_DIV; abs_src = n1;
      end
      ctpd_pkg::P_L12, ctpd_pkg::P_Q6: begin
        iss = ctpd_pkg::I_DIV; abs_src = n2;
      end
      ctpd_pkg::P_L17, ctpd_pkg::P_Q2: iss = ctpd_pkg::I_SQRT;
      ctpd_pkg::P_L18, ctpd_pkg::P_QZ, ctpd_pkg::P_Q7: iss = ctpd_pkg::I_OUT;
      ctpd_pkg::P_Q3, ctpd_pkg::P_Q4: begin
        iss = ctpd_pkg::I_MAC; m_op = AW'(radius_reg); clr_op = 1'b1;
        q_op = (pc == ctpd_pkg::P_Q3) ? x2 : y2;
      end
      default: ;
    endcase
  end

  // query result helpers
  logic [RTW:0] gdiff, gabs;
  logic [RW-1:0] gap_cap, rad_cap;
  assign gdiff   = (RTW+1)'(qdist) - (RTW+1)'(radius_reg);
  assign gabs    = gdiff[RTW] ? ((RTW+1)'(0) - gdiff) : gdiff;
  assign gap_cap = (gabs[RTW:RW] != '0) ? ctpd_pkg::RMAX : gabs[RW-1:0];
  assign rad_cap = (qr[QW-1:RW] != '0) ? ctpd_pkg::RMAX : qr[RW-1:0];

  logic [QW:0] q_inc;
  assign q_inc = {1'b0, qr} + (QW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ctpd_pkg::ST_IDLE;
      pc           <= ctpd_pkg::P_L0;
      center_x_reg <= '0;
      center_y_reg <= '0;
      radius_reg   <= '0;
    end else begin
      unique case (st)
        ctpd_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            ax_q <= in_ax;
            ay_q <= in_ay;
            st   <= ctpd_pkg::ST_ISSUE;
            if (s_tuser) begin
              x2 <= {in_ax[CW-1], in_ax} - {center_x_reg[CW-1], center_x_reg};
              y2 <= {in_ay[CW-1], in_ay} - {center_y_reg[CW-1], center_y_reg};
              pc <= (in_ax == center_x_reg && in_ay == center_y_reg) ?
                    ctpd_pkg::P_QZ : ctpd_pkg::P_Q0;
            end else begin
              x2 <= {in_bx[CW-1], in_bx} - {in_ax[CW-1], in_ax};
              y2 <= {in_by[CW-1], in_by} - {in_ay[CW-1], in_ay};
              x3 <= {in_cx[CW-1], in_cx} - {in_ax[CW-1], in_ax};
              y3 <= {in_cy[CW-1], in_cy} - {in_ay[CW-1], in_ay};
              pc <= ctpd_pkg::P_L0;
            end
          end
        end
        ctpd_pkg::ST_ISSUE: begin
          pc <= pc + PW'(1);
          unique case (iss)
            ctpd_pkg::I_MAC: begin
              if (clr_op) acc <= '0;
              sh      <= m_op;
              qr      <= QW'(q_op);
              mac_sub <= sub_op;
              cnt     <= '0;
              st      <= ctpd_pkg::ST_MAC;
            end
            ctpd_pkg::I_DIV: begin
              sh  <= abs_val;
              acc <= '0;
              qr  <= '0;
              ovf <= 1'b0;
              cnt <= '0;
              st  <= ctpd_pkg::ST_DIV;
            end
            ctpd_pkg::I_SQRT: begin
              sh  <= {acc[DW-1:0], {(AW-DW){1'b0}}};
              acc <= '0;
              qr  <= '0;
              cnt <= '0;
              st  <= ctpd_pkg::ST_SQRT;
            end
            ctpd_pkg::I_OUT: st <= ctpd_pkg::ST_OUT;
            default: ;
          endcase
          unique case (pc)
            ctpd_pkg::P_L2: r2 <= acc;
            ctpd_pkg::P_L4: r3 <= acc;
            ctpd_pkg::P_L6: begin
              det    <= acc;
              degen  <= (acc == '0);
              near_x <= '0;
              near_y <= '0;
              gap    <= '0;
            end
            ctpd_pkg::P_L8: n1 <= acc;
            ctpd_pkg::P_L10: begin
              n2   <= acc;
              dv   <= {abs_val[DW-2:0], 1'b0};
              dneg <= det[AW-1];
            end
            ctpd_pkg::P_L11: neg_q <= n1[AW-1] ^ dneg;
            ctpd_pkg::P_L12: begin
              center_x_reg <= ctpd_pkg::place(ax_q, qr, ovf, neg_q);
              neg_q        <= n2[AW-1] ^ dneg;
            end
            ctpd_pkg::P_L13: center_y_reg <= ctpd_pkg::place(ay_q, qr, ovf, neg_q);
            ctpd_pkg::P_L14: begin
              x2 <= {center_x_reg[CW-1], center_x_reg} - {ax_q[CW-1], ax_q};
              y2 <= {center_y_reg[CW-1], center_y_reg} - {ay_q[CW-1], ay_q};
            end
            ctpd_pkg::P_L18: radius_reg <= rad_cap;
            ctpd_pkg::P_QZ: begin
              near_x <= ctpd_pkg::place(center_x_reg, QW'(radius_reg), 1'b0, 1'b0);
              near_y <= center_y_reg;
              gap    <= radius_reg;
              degen  <= 1'b0;
            end
            ctpd_pkg::P_Q3: begin
              qdist <= qr[RTW-1:0];
              dv    <= DW'(qr[RTW-1:0]);
            end
            ctpd_pkg::P_Q4: n1 <= acc;
            ctpd_pkg::P_Q5: begin
              n2    <= acc;
              neg_q <= n1[AW-1];
            end
            ctpd_pkg::P_Q6: begin
              near_x <= ctpd_pkg::place(center_x_reg, qr, ovf, neg_q);
              neg_q  <= n2[AW-1];
            end
            ctpd_pkg::P_Q7: begin
              near_y <= ctpd_pkg::place(center_y_reg, qr, ovf, neg_q);
              gap    <= gap_cap;
              degen  <= 1'b0;
            end
            default: ;
          endcase
        end
        ctpd_pkg::ST_MAC: begin
          acc <= alu_res[AW-1:0];
          sh  <= {sh[AW-2:0], 1'b0};
          qr  <= {1'b0, qr[QW-1:1]};
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(MW-1)) st <= ctpd_pkg::ST_ISSUE;
        end
        ctpd_pkg::ST_DIV: begin
          acc <= borrow ? {acc[AW-2:0], sh[AW-1]} : alu_res[AW-1:0];
          qr  <= {qr[QW-2:0], ~borrow};
          ovf <= ovf | qr[QW-1];  // sticky: quotient far outside range
          sh  <= {sh[AW-2:0], 1'b0};
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(AW-1)) st <= ctpd_pkg::ST_DIVR;
        end
        ctpd_pkg::ST_DIVR: begin
          if (!borrow) begin
            qr  <= q_inc[QW-1:0];
            ovf <= ovf | q_inc[QW];
          end
          st <= ctpd_pkg::ST_ISSUE;
        end
        ctpd_pkg::ST_SQRT: begin
          if (!borrow) acc <= alu_res[AW-1:0];
          else acc <= {acc[AW-3:0], sh[AW-1:AW-2]};
          qr  <= {qr[QW-2:0], ~borrow};
          sh  <= {sh[AW-3:0], 2'b00};
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(RTW-1)) st <= ctpd_pkg::ST_SQRR;
        end
        ctpd_pkg::ST_SQRR: begin
          // remainder above root: round up
          if (borrow) qr <= q_inc[QW-1:0];
          st <= ctpd_pkg::ST_ISSUE;
        end
        ctpd_pkg::ST_OUT: begin
          if (m_tready) st <= ctpd_pkg::ST_IDLE;
        end
        default: st <= ctpd_pkg::ST_IDLE;
      endcase
    end
  end

  assign s_tready = (st == ctpd_pkg::ST_IDLE);
  assign m_tvalid = (st == ctpd_pkg::ST_OUT);
  assign m_tuser  = degen;
  assign m_tdata  = ctpd_pkg::OUTW'({gap, near_y, near_x, radius_reg,
                                     center_y_reg, center_x_reg});

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input and output open together");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");

  a_rem: assert property (@(posedge clk) disable iff (rst)
    st == ctpd_pkg::ST_DIV |-> AW'(dv) > acc) else $error("remainder not below divisor");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> gap == '0 && near_x == '0 && near_y == '0)
    else $error("collinear word carries query data");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for circle_three_point_and_distance: drives load and query words,
// predicts the circumcircle and nearest-point results, and checks the outputs.
// Depends on ctpd_pkg and the block RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wide_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
  localparam longint SMAX     = 64'sd2147483647;
  localparam longint SMIN     = -64'sd2147483648;
  localparam longint RLIM     = 64'sd2147483647;
  localparam longint QCAP     = 64'sd1 <<< 62;
  localparam int     ONE      = 65536;
  localparam int     STALL_LIMIT = 20000;
  localparam int     HOLD_CYCLES = 3000;

  typedef struct packed {
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic [30:0]        rad;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [30:0]        gap;
    logic               degen;
  } circle_res_t;

  class circle_scoreboard;
    longint cen_x, cen_y, rad;
    circle_res_t pending[$];
    int errors;

    function new();
      cen_x = 0; cen_y = 0; rad = 0; errors = 0;
    endfunction

    function longint clamp(longint v);
      return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
    endfunction

    // rounded |num|/|den| applied to base with the sign of num/den
    function longint shift_round(longint base, wide_t num, wide_t den);
      wide_t an, ad, q, r;
      logic neg;
      neg = (num < 0) != (den < 0);
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = an / ad;
      r = an % ad;
      if (2 * r >= ad) q = q + 1;
      if (q > QCAP) q = QCAP;
      return clamp(neg ? base - longint'(q) : base + longint'(q));
    endfunction

    function wide_t root_round(wide_t a);
      wide_t s, c;
      s = 0;
      for (int i = 95; i >= 0; i--) begin
        c = s | (wide_t'(1) << i);
        if (c * c <= a) s = c;
      end
      if (a - s * s > s) s = s + 1;
      return s;
    endfunction

    function void note_word(logic func, logic [ctpd_pkg::INW-1:0] d);
      longint ax, ay, x2, y2, x3, y3, dx, dy, qdist, g;
      wide_t r2, r3, det, numx, numy, dw;
      circle_res_t e;
      ax = longint'($signed(d[31:0]));
      ay = longint'($signed(d[63:32]));
      e = '0;
      if (func == FUNC_LOAD) begin
        x2 = longint'($signed(d[95:64])) - ax;
        y2 = longint'($signed(d[127:96])) - ay;
        x3 = longint'($signed(d[159:128])) - ax;
        y3 = longint'($signed(d[191:160])) - ay;
        r2 = wide_t'(x2) * x2 + wide_t'(y2) * y2;
        r3 = wide_t'(x3) * x3 + wide_t'(y3) * y3;
        det = wide_t'(x2) * y3 - wide_t'(y2) * x3;
        if (det == 0) e.degen = 1'b1;
        else begin
          numx = wide_t'(y3) * r2 - wide_t'(y2) * r3;
          numy = wide_t'(x2) * r3 - wide_t'(x3) * r2;
          cen_x = shift_round(ax, numx, 2 * det);
          cen_y = shift_round(ay, numy, 2 * det);
          dw = root_round(wide_t'(cen_x - ax) * (cen_x - ax) +
                          wide_t'(cen_y - ay) * (cen_y - ay));
          rad = dw > RLIM ? RLIM : longint'(dw);
        end
      end else begin
        dx = ax - cen_x;
        dy = ay - cen_y;
        if (dx == 0 && dy == 0) begin
          e.nx = 32'(clamp(cen_x + rad));
          e.ny = 32'(cen_y);
          e.gap = 31'(rad);
        end else begin
          dw = root_round(wide_t'(dx) * dx + wide_t'(dy) * dy);
          qdist = longint'(dw);
          e.nx = 32'(shift_round(cen_x, wide_t'(rad) * dx, dw));
          e.ny = 32'(shift_round(cen_y, wide_t'(rad) * dy, dw));
          g = qdist > rad ? qdist - rad : rad - qdist;
          e.gap = 31'(g > RLIM ? RLIM : g);
        end
      end
      e.cen_x = 32'(cen_x);
      e.cen_y = 32'(cen_y);
      e.rad = 31'(rad);
      pending = {pending, e};
    endfunction

    function void field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(logic [ctpd_pkg::OUTW-1:0] d, logic degen);
      circle_res_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      field("center_x", longint'(e.cen_x), longint'($signed(d[31:0])));
      field("center_y", longint'(e.cen_y), longint'($signed(d[63:32])));
      field("radius", longint'(e.rad), longint'(d[94:64]));
      field("near_x", longint'(e.nx), longint'($signed(d[126:95])));
      field("near_y", longint'(e.ny), longint'($signed(d[158:127])));
      field("gap", longint'(e.gap), longint'(d[189:159]));
      field("degenerate", longint'(e.degen), longint'(degen));
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [ctpd_pkg::INW-1:0] s_tdata;
  logic m_tvalid, m_tready, m_tuser;
  logic [ctpd_pkg::OUTW-1:0] m_tdata;

  circle_scoreboard sb;
  int send_idle, recv_idle;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int quiet;

  circle_three_point_and_distance DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(logic func, logic [ctpd_pkg::INW-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_word(func, d);
  endtask

  task automatic load_pts(int ax, int ay, int bx, int by, int cx, int cy);
    send_word(FUNC_LOAD, {cy, cx, by, bx, ay, ax});
  endtask

  task automatic query_pt(int px, int py);
    send_word(FUNC_QUERY, {128'd0, py, px});
  endtask

  function automatic int rnd_coord();
    case ($urandom_range(9))
      0, 1: return int'($urandom);
      2:    return $urandom_range(1) ? int'(SMAX) : int'(SMIN);
      default: return int'($urandom_range(40 * ONE)) - 20 * ONE;
    endcase
  endfunction

  task automatic random_item();
    int ax, ay, bx, by, k;
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      ax = rnd_coord(); ay = rnd_coord(); bx = rnd_coord(); by = rnd_coord();
      if (sel < 6) begin
        // collinear third point
        k = int'($urandom_range(6)) - 3;
        load_pts(ax, ay, bx, by, ax + k * (bx - ax), ay + k * (by - ay));
      end else if (sel < 9) begin
        load_pts(ax, ay, ax, ay, bx, by);
      end else begin
        load_pts(ax, ay, bx, by, rnd_coord(), rnd_coord());
      end
    end else if (sel < 48) begin
      query_pt(int'(sb.cen_x), int'(sb.cen_y));
    end else if (sel < 95) begin
      query_pt(int'(sb.cen_x) + int'($urandom_range(8 * ONE)) - 4 * ONE,
               rnd_coord());
    end else begin
      send_word(FUNC_QUERY, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    hold_req = 1'b0;
    send_idle = 29;
    recv_idle = 78;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words
    query_pt(0, 0);
    query_pt(3 * ONE, 0);
    load_pts(0, 0, 2 * ONE, 0, 0, 2 * ONE);
    query_pt(3 * ONE, ONE);
    query_pt(ONE, ONE);
    query_pt(int'(SMIN), int'(SMIN));
    query_pt(int'(SMAX), int'(SMAX));
    load_pts(0, 0, ONE, ONE, 2 * ONE, 2 * ONE);
    load_pts(5, 5, 5, 5, 5, 5);
    load_pts(int'(SMIN), int'(SMIN), int'(SMAX), int'(SMIN), int'(SMIN), int'(SMAX));
    query_pt(int'(sb.cen_x), int'(sb.cen_y));
    query_pt(int'(SMIN), int'(SMAX));
    load_pts(0, 0, int'(SMAX), 1, int'(SMIN), 0);
    query_pt(int'(sb.cen_x), int'(sb.cen_y));
    query_pt(0, 0);
    load_pts(int'(SMAX), int'(SMAX), int'(SMIN), int'(SMIN), int'(SMAX), int'(SMIN));
    query_pt(int'(SMAX), 0);
    load_pts(1, 0, 0, 1, -1, 0);
    query_pt(0, 0);
    query_pt(int'(SMAX), int'(SMIN));
    send_word(FUNC_QUERY, {192{1'b1}});

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 78; recv_idle = 29; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; hold_req = 1'b1; end
      repeat (160) random_item();
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/ctpd_pkg.sv
hw/rtl/circle_three_point_and_distance.sv
tb/sv/tb.sv
